FILE: rtl/lav_pkg.sv
// Shared constants and beat types of the look-at view matrix block.
package lav_pkg;

	localparam int DATA_W        = 32;
	localparam int FRAC_BITS_DEF = 16;

	// Normalized magnitudes keep their largest component in [2^29, 2^30).
	localparam int NORM_MSB = 29;
	localparam int NORM_W   = NORM_MSB + 1;
	localparam int ROOT_W   = NORM_W + 1;
	localparam int SUMSQ_W  = 64;

	localparam logic [1:0] COL_0 = 2'd0;
	localparam logic [1:0] COL_1 = 2'd1;
	localparam logic [1:0] COL_2 = 2'd2;
	localparam logic [1:0] COL_3 = 2'd3;

	typedef logic signed [DATA_W-1:0] word_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] eye_x;
		logic signed [DATA_W-1:0] eye_y;
		logic signed [DATA_W-1:0] eye_z;
		logic signed [DATA_W-1:0] target_x;
		logic signed [DATA_W-1:0] target_y;
		logic signed [DATA_W-1:0] target_z;
		logic signed [DATA_W-1:0] up_hint_x;
		logic signed [DATA_W-1:0] up_hint_y;
		logic signed [DATA_W-1:0] up_hint_z;
	} lav_in_t;

	typedef struct packed {
		logic [1:0]               column_index;
		logic signed [DATA_W-1:0] elem_row0;
		logic signed [DATA_W-1:0] elem_row1;
		logic signed [DATA_W-1:0] elem_row2;
		logic signed [DATA_W-1:0] elem_row3;
		logic                     last_column;
	} lav_out_t;

endpackage

FILE: rtl/lav_in_if.sv
// Camera input channel: valid/ready handshake carrying eye, target and up hint.
interface lav_in_if import lav_pkg::*; ();
	logic    valid;
	logic    ready;
	lav_in_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/lav_out_if.sv
// Matrix column output channel: valid/ready handshake carrying one column.
interface lav_out_if import lav_pkg::*; ();
	logic     valid;
	logic     ready;
	lav_out_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/lav_unit.sv
// Pipelined unit-length scaler for a signed 3-vector, with a passed-along sideband.
module lav_unit import lav_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int VW        = 33,
	parameter int SBW       = 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [3*VW-1:0]             in_vec,
	input  logic [SBW-1:0]              in_sb,
	output logic                        out_valid,
	output logic [3*(FRAC_BITS+2)-1:0]  out_vec,
	output logic [SBW-1:0]              out_sb
);

	localparam int FW       = FRAC_BITS + 2;
	localparam int PW       = $clog2(VW);
	localparam int QW       = FRAC_BITS + 1;
	localparam int DW       = NORM_W + FRAC_BITS + 1;
	localparam int SQ_STEPS = SUMSQ_W / 2;

	// stage 1: magnitudes and signs
	logic [2:0][VW-1:0] mag_s1;
	logic [2:0]         neg_s1;
	logic [SBW-1:0]     sb_s1;
	logic               v_s1;

	// stage 2: leading one of the largest magnitude
	logic [2:0][VW-1:0] mag_s2;
	logic [2:0]         neg_s2;
	logic [PW-1:0]      pos_s2;
	logic               nz_s2;
	logic [SBW-1:0]     sb_s2;
	logic               v_s2;

	// stage 3: normalized magnitudes
	logic [2:0][NORM_W-1:0] m_s3;
	logic [2:0]             neg_s3;
	logic                   nz_s3;
	logic [SBW-1:0]         sb_s3;
	logic                   v_s3;

	// stage 4: squares
	logic [2:0][2*NORM_W-1:0] sq_s4;
	logic [2:0][NORM_W-1:0]   m_s4;
	logic [2:0]               neg_s4;
	logic                     nz_s4;
	logic [SBW-1:0]           sb_s4;
	logic                     v_s4;

	// square root steps, index k holds the state entering step k
	logic [SUMSQ_W-1:0]     rem_sk  [0:SQ_STEPS];
	logic [SUMSQ_W-1:0]     root_sk [0:SQ_STEPS];
	logic [2:0][NORM_W-1:0] sm_sk   [0:SQ_STEPS];
	logic [2:0]             sneg_sk [0:SQ_STEPS];
	logic                   snz_sk  [0:SQ_STEPS];
	logic [SBW-1:0]         ssb_sk  [0:SQ_STEPS];
	logic                   vs_sk   [0:SQ_STEPS];

	// division steps, index j holds the state entering step j
	logic [2:0][DW-1:0]     dr_sk   [0:QW];
	logic [2:0][QW-1:0]     dq_sk   [0:QW];
	logic [ROOT_W-1:0]      dl_sk   [0:QW];
	logic [2:0]             dneg_sk [0:QW];
	logic                   dnz_sk  [0:QW];
	logic [SBW-1:0]         dsb_sk  [0:QW];
	logic                   vd_sk   [0:QW];

	// final stage
	logic [3*FW-1:0] uvec_sf;
	logic [SBW-1:0]  sb_sf;
	logic            v_sf;

	logic [2:0][VW-1:0]     mag_c;
	logic [2:0]             neg_c;
	logic [VW-1:0]          or_c;
	logic [PW-1:0]          pos_c;
	logic [2:0][NORM_W-1:0] m_c;
	logic [VW-1:0]          sh_c;
	logic [ROOT_W-1:0]      len_c;
	logic [3*FW-1:0]        uvec_c;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			neg_c[i] = in_vec[i*VW + VW - 1];
			mag_c[i] = neg_c[i] ? (~in_vec[i*VW +: VW] + VW'(1)) : in_vec[i*VW +: VW];
		end
	end

	always_comb begin
		or_c  = mag_s1[0] | mag_s1[1] | mag_s1[2];
		pos_c = '0;
		for (int b = 0; b < VW; b++) begin
			if (or_c[b]) begin
				pos_c = PW'(b);
			end
		end
	end

	// one shift for all three, right shifts truncate
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (pos_s2 >= PW'(NORM_MSB)) begin
				sh_c = mag_s2[i] >> (pos_s2 - PW'(NORM_MSB));
			end else begin
				sh_c = mag_s2[i] << (PW'(NORM_MSB) - pos_s2);
			end
			m_c[i] = sh_c[NORM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			v_s4     <= 1'b0;
			vs_sk[0] <= 1'b0;
		end else if (en) begin
			v_s1     <= in_valid;
			v_s2     <= v_s1;
			v_s3     <= v_s2;
			v_s4     <= v_s3;
			vs_sk[0] <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1 <= mag_c;
			neg_s1 <= neg_c;
			sb_s1  <= in_sb;

			mag_s2 <= mag_s1;
			neg_s2 <= neg_s1;
			pos_s2 <= pos_c;
			nz_s2  <= |or_c;
			sb_s2  <= sb_s1;

			m_s3   <= m_c;
			neg_s3 <= neg_s2;
			nz_s3  <= nz_s2;
			sb_s3  <= sb_s2;

			for (int i = 0; i < 3; i++) begin
				sq_s4[i] <= m_s3[i] * m_s3[i];
			end
			m_s4   <= m_s3;
			neg_s4 <= neg_s3;
			nz_s4  <= nz_s3;
			sb_s4  <= sb_s3;

			rem_sk[0]  <= SUMSQ_W'(sq_s4[0]) + SUMSQ_W'(sq_s4[1]) + SUMSQ_W'(sq_s4[2]);
			root_sk[0] <= '0;
			sm_sk[0]   <= m_s4;
			sneg_sk[0] <= neg_s4;
			snz_sk[0]  <= nz_s4;
			ssb_sk[0]  <= sb_s4;
		end
	end

	// bit-pair square root, one result bit per stage
	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
		localparam logic [SUMSQ_W-1:0] BIT = SUMSQ_W'(1) << (SUMSQ_W - 2 - 2*k);
		logic [SUMSQ_W-1:0] trial;
		logic               take;

		assign trial = root_sk[k] + BIT;
		assign take  = rem_sk[k] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vs_sk[k+1] <= 1'b0;
			end else if (en) begin
				vs_sk[k+1] <= vs_sk[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_sk[k+1]  <= take ? (rem_sk[k] - trial) : rem_sk[k];
				root_sk[k+1] <= take ? ((root_sk[k] >> 1) + BIT) : (root_sk[k] >> 1);
				sm_sk[k+1]   <= sm_sk[k];
				sneg_sk[k+1] <= sneg_sk[k];
				snz_sk[k+1]  <= snz_sk[k];
				ssb_sk[k+1]  <= ssb_sk[k];
			end
		end
	end

	assign len_c = root_sk[SQ_STEPS][ROOT_W-1:0];

	// dividend with half the divisor added: rounds half away from zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vd_sk[0] <= 1'b0;
		end else if (en) begin
			vd_sk[0] <= vs_sk[SQ_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				dr_sk[0][i] <= (DW'(sm_sk[SQ_STEPS][i]) << FRAC_BITS) + DW'(len_c >> 1);
			end
			dq_sk[0]   <= '0;
			dl_sk[0]   <= len_c;
			dneg_sk[0] <= sneg_sk[SQ_STEPS];
			dnz_sk[0]  <= snz_sk[SQ_STEPS];
			dsb_sk[0]  <= ssb_sk[SQ_STEPS];
		end
	end

	// restoring division, one quotient bit per stage, three lanes share the divisor
	for (genvar j = 0; j < QW; j++) begin : g_div
		localparam int SH = QW - 1 - j;
		logic [DW-1:0] dv;

		assign dv = DW'(dl_sk[j]) << SH;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vd_sk[j+1] <= 1'b0;
			end else if (en) begin
				vd_sk[j+1] <= vd_sk[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					if (dr_sk[j][i] >= dv) begin
						dr_sk[j+1][i] <= dr_sk[j][i] - dv;
						dq_sk[j+1][i] <= dq_sk[j][i] | (QW'(1) << SH);
					end else begin
						dr_sk[j+1][i] <= dr_sk[j][i];
						dq_sk[j+1][i] <= dq_sk[j][i];
					end
				end
				dl_sk[j+1]   <= dl_sk[j];
				dneg_sk[j+1] <= dneg_sk[j];
				dnz_sk[j+1]  <= dnz_sk[j];
				dsb_sk[j+1]  <= dsb_sk[j];
			end
		end
	end

	// put the sign back; a zero vector stays zero
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (!dnz_sk[QW]) begin
				uvec_c[i*FW +: FW] = '0;
			end else if (dneg_sk[QW][i]) begin
				uvec_c[i*FW +: FW] = -FW'(dq_sk[QW][i]);
			end else begin
				uvec_c[i*FW +: FW] = FW'(dq_sk[QW][i]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sf <= 1'b0;
		end else if (en) begin
			v_sf <= vd_sk[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			uvec_sf <= uvec_c;
			sb_sf   <= dsb_sk[QW];
		end
	end

	assign out_valid = v_sf;
	assign out_vec   = uvec_sf;
	assign out_sb    = sb_sf;

endmodule

FILE: rtl/look_at_view_matrix.sv
// Top level of the look-at view matrix pipeline with its column serializer.
//
// Usage:
//   cam carries one camera pose per beat: eye, target and up hint, each
//   component signed fixed point with FRAC_BITS fraction bits. mat returns
//   the 4x4 view matrix as four beats, one column each, column-major:
//   columns 0..2 hold (side, up, -forward, 0), column 3 holds the
//   translation (-side.eye, -up.eye, forward.eye, 1.0); last_column marks
//   the fourth beat. Elements saturate to the signed 32-bit range.
//   Path: a pose passes s1, the forward scaler, s2 and s3, the side
//   scaler, s4 to s9 and the serializer register; each scaler is a
//   32-step square root followed by a FRAC_BITS+1 step divider.
//   Throughput: a pose may enter every cycle while cam.ready is high;
//   the column serializer sends four beats per pose and so limits the sustained rate.
//   Stall: while mat is held off the serializer keeps its column; the
//   whole pipeline freezes in place, and cam.ready drops, only while the
//   last stage holds a pose the serializer cannot take. Nothing is lost or repeated.
//   Reset: arst_n clears every valid bit and the serializer; the block is
//   ready for a pose in the first cycle after reset releases.
module look_at_view_matrix import lav_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	lav_in_if.sink    cam,
	lav_out_if.source mat
);

	localparam int FW   = FRAC_BITS + 2;   // unit component, |x| <= 1.0
	localparam int FHW  = FW + DATA_W;     // forward * hint
	localparam int CW   = FHW + 1;         // forward x hint
	localparam int SFW  = 2 * FW;          // side * forward
	localparam int UW   = SFW + 1;         // side x forward, Q.2F
	localparam int DPW  = FW + DATA_W;     // axis * eye
	localparam int TW   = DPW + 2;         // three-term dot product
	localparam int PRW  = 2 * DATA_W;
	localparam int SA_W = 6 * DATA_W;
	localparam int SB_W = 3 * DATA_W + 3 * FW;

	localparam logic signed [PRW-1:0] WMAX = (PRW'(1) <<< (DATA_W - 1)) - PRW'(1);
	localparam logic signed [PRW-1:0] WMIN = -(PRW'(1) <<< (DATA_W - 1));
	localparam word_t                 ONE_Q = DATA_W'(1) << FRAC_BITS;

	// shift right by FRAC_BITS, rounding half away from zero
	function automatic logic signed [PRW-1:0] rnd(input logic signed [PRW-1:0] v);
		logic [PRW-1:0] m;
		m = v[PRW-1] ? PRW'(-v) : PRW'(v);
		m = (m + (PRW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
		rnd = v[PRW-1] ? -$signed(m) : $signed(m);
	endfunction

	function automatic word_t sat(input logic signed [PRW-1:0] v);
		if (v > WMAX) begin
			sat = WMAX[DATA_W-1:0];
		end else if (v < WMIN) begin
			sat = WMIN[DATA_W-1:0];
		end else begin
			sat = v[DATA_W-1:0];
		end
	endfunction

	logic adv;
	logic load;
	logic load_ok;

	// s1: register the pose, form target - eye
	logic signed [DATA_W:0]   diff_s1 [3];
	logic signed [DATA_W-1:0] eye_s1  [3];
	logic signed [DATA_W-1:0] hint_s1 [3];
	logic                     v_s1;

	// forward scaler
	logic            va;
	logic [3*FW-1:0] fwd_vec;
	logic [SA_W-1:0] sba;

	logic signed [FW-1:0]     fwd_a  [3];
	logic signed [DATA_W-1:0] eye_a  [3];
	logic signed [DATA_W-1:0] hint_a [3];

	// s2: forward * hint products
	logic signed [FHW-1:0]    fh_s2  [6];
	logic signed [DATA_W-1:0] eye_s2 [3];
	logic signed [FW-1:0]     fwd_s2 [3];
	logic                     v_s2;

	// s3: forward x hint
	logic signed [CW-1:0]     cr_s3  [3];
	logic signed [DATA_W-1:0] eye_s3 [3];
	logic signed [FW-1:0]     fwd_s3 [3];
	logic                     v_s3;

	// side scaler
	logic            vb;
	logic [3*FW-1:0] side_vec;
	logic [SB_W-1:0] sbb;

	logic signed [FW-1:0]     side_b [3];
	logic signed [FW-1:0]     fwd_b  [3];
	logic signed [DATA_W-1:0] eye_b  [3];

	// s4: side * forward, side * eye, forward * eye
	logic signed [SFW-1:0]    sf_s4   [6];
	logic signed [DPW-1:0]    se_s4   [3];
	logic signed [DPW-1:0]    fe_s4   [3];
	logic signed [DATA_W-1:0] eye_s4  [3];
	logic signed [FW-1:0]     side_s4 [3];
	logic signed [FW-1:0]     fwd_s4  [3];
	logic                     v_s4;

	// s5: raw up, side.eye, forward.eye
	logic signed [UW-1:0]     upr_s5  [3];
	logic signed [TW-1:0]     t0_s5;
	logic signed [TW-1:0]     t2_s5;
	logic signed [DATA_W-1:0] eye_s5  [3];
	logic signed [FW-1:0]     side_s5 [3];
	logic signed [FW-1:0]     fwd_s5  [3];
	logic                     v_s5;

	// s6: rounded up, translation rows 0 and 2
	word_t                    up_s6   [3];
	word_t                    r0_s6;
	word_t                    r2_s6;
	logic signed [DATA_W-1:0] eye_s6  [3];
	logic signed [FW-1:0]     side_s6 [3];
	logic signed [FW-1:0]     fwd_s6  [3];
	logic                     v_s6;

	// s7: up * eye
	logic signed [PRW-1:0] ue_s7   [3];
	word_t                 up_s7   [3];
	word_t                 r0_s7;
	word_t                 r2_s7;
	logic signed [FW-1:0]  side_s7 [3];
	logic signed [FW-1:0]  fwd_s7  [3];
	logic                  v_s7;

	// s8: up.eye
	logic signed [PRW-1:0] t1_s8;
	word_t                 up_s8   [3];
	word_t                 r0_s8;
	word_t                 r2_s8;
	logic signed [FW-1:0]  side_s8 [3];
	logic signed [FW-1:0]  fwd_s8  [3];
	logic                  v_s8;

	// s9: translation row 1, whole matrix ready for the serializer
	word_t                 r1_s9;
	word_t                 up_s9   [3];
	word_t                 r0_s9;
	word_t                 r2_s9;
	logic signed [FW-1:0]  side_s9 [3];
	logic signed [FW-1:0]  fwd_s9  [3];
	logic                  v_s9;

	// serializer holding register
	logic                 busy_q;
	logic [1:0]           col_q;
	word_t                up_q   [3];
	word_t                r0_q;
	word_t                r1_q;
	word_t                r2_q;
	logic signed [FW-1:0] side_q [3];
	logic signed [FW-1:0] fwd_q  [3];

	// Advance the whole pipeline unless the last stage holds a pose that
	// the serializer cannot take this cycle.
	assign load_ok   = !busy_q || (mat.ready && (col_q == COL_3));
	assign adv       = !v_s9 || load_ok;
	assign load      = v_s9 && load_ok;
	assign cam.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= cam.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			eye_s1[0]  <= cam.data.eye_x;
			eye_s1[1]  <= cam.data.eye_y;
			eye_s1[2]  <= cam.data.eye_z;
			hint_s1[0] <= cam.data.up_hint_x;
			hint_s1[1] <= cam.data.up_hint_y;
			hint_s1[2] <= cam.data.up_hint_z;
			diff_s1[0] <= (DATA_W+1)'(cam.data.target_x) - (DATA_W+1)'(cam.data.eye_x);
			diff_s1[1] <= (DATA_W+1)'(cam.data.target_y) - (DATA_W+1)'(cam.data.eye_y);
			diff_s1[2] <= (DATA_W+1)'(cam.data.target_z) - (DATA_W+1)'(cam.data.eye_z);
		end
	end

	lav_unit #(
		.FRAC_BITS (FRAC_BITS),
		.VW        (DATA_W + 1),
		.SBW       (SA_W)
	) u_fwd (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s1),
		.in_vec    ({diff_s1[2], diff_s1[1], diff_s1[0]}),
		.in_sb     ({hint_s1[2], hint_s1[1], hint_s1[0], eye_s1[2], eye_s1[1], eye_s1[0]}),
		.out_valid (va),
		.out_vec   (fwd_vec),
		.out_sb    (sba)
	);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			fwd_a[i]  = $signed(fwd_vec[i*FW +: FW]);
			eye_a[i]  = $signed(sba[i*DATA_W +: DATA_W]);
			hint_a[i] = $signed(sba[(i+3)*DATA_W +: DATA_W]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s2 <= va;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fh_s2[0] <= fwd_a[1] * hint_a[2];
			fh_s2[1] <= fwd_a[2] * hint_a[1];
			fh_s2[2] <= fwd_a[2] * hint_a[0];
			fh_s2[3] <= fwd_a[0] * hint_a[2];
			fh_s2[4] <= fwd_a[0] * hint_a[1];
			fh_s2[5] <= fwd_a[1] * hint_a[0];
			eye_s2   <= eye_a;
			fwd_s2   <= fwd_a;

			cr_s3[0] <= CW'(fh_s2[0]) - CW'(fh_s2[1]);
			cr_s3[1] <= CW'(fh_s2[2]) - CW'(fh_s2[3]);
			cr_s3[2] <= CW'(fh_s2[4]) - CW'(fh_s2[5]);
			eye_s3   <= eye_s2;
			fwd_s3   <= fwd_s2;
		end
	end

	lav_unit #(
		.FRAC_BITS (FRAC_BITS),
		.VW        (CW),
		.SBW       (SB_W)
	) u_side (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s3),
		.in_vec    ({cr_s3[2], cr_s3[1], cr_s3[0]}),
		.in_sb     ({fwd_s3[2], fwd_s3[1], fwd_s3[0], eye_s3[2], eye_s3[1], eye_s3[0]}),
		.out_valid (vb),
		.out_vec   (side_vec),
		.out_sb    (sbb)
	);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			side_b[i] = $signed(side_vec[i*FW +: FW]);
			eye_b[i]  = $signed(sbb[i*DATA_W +: DATA_W]);
			fwd_b[i]  = $signed(sbb[3*DATA_W + i*FW +: FW]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else if (adv) begin
			v_s4 <= vb;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// true up = side x forward
			sf_s4[0] <= side_b[1] * fwd_b[2];
			sf_s4[1] <= side_b[2] * fwd_b[1];
			sf_s4[2] <= side_b[2] * fwd_b[0];
			sf_s4[3] <= side_b[0] * fwd_b[2];
			sf_s4[4] <= side_b[0] * fwd_b[1];
			sf_s4[5] <= side_b[1] * fwd_b[0];
			for (int i = 0; i < 3; i++) begin
				se_s4[i] <= side_b[i] * eye_b[i];
				fe_s4[i] <= fwd_b[i] * eye_b[i];
			end
			eye_s4  <= eye_b;
			side_s4 <= side_b;
			fwd_s4  <= fwd_b;

			upr_s5[0] <= UW'(sf_s4[0]) - UW'(sf_s4[1]);
			upr_s5[1] <= UW'(sf_s4[2]) - UW'(sf_s4[3]);
			upr_s5[2] <= UW'(sf_s4[4]) - UW'(sf_s4[5]);
			t0_s5     <= TW'(se_s4[0]) + TW'(se_s4[1]) + TW'(se_s4[2]);
			t2_s5     <= TW'(fe_s4[0]) + TW'(fe_s4[1]) + TW'(fe_s4[2]);
			eye_s5    <= eye_s4;
			side_s5   <= side_s4;
			fwd_s5    <= fwd_s4;

			for (int i = 0; i < 3; i++) begin
				up_s6[i] <= sat(rnd(PRW'(upr_s5[i])));
			end
			r0_s6   <= sat(-rnd(PRW'(t0_s5)));
			r2_s6   <= sat(rnd(PRW'(t2_s5)));
			eye_s6  <= eye_s5;
			side_s6 <= side_s5;
			fwd_s6  <= fwd_s5;

			for (int i = 0; i < 3; i++) begin
				ue_s7[i] <= up_s6[i] * eye_s6[i];
			end
			up_s7   <= up_s6;
			r0_s7   <= r0_s6;
			r2_s7   <= r2_s6;
			side_s7 <= side_s6;
			fwd_s7  <= fwd_s6;

			t1_s8   <= ue_s7[0] + ue_s7[1] + ue_s7[2];
			up_s8   <= up_s7;
			r0_s8   <= r0_s7;
			r2_s8   <= r2_s7;
			side_s8 <= side_s7;
			fwd_s8  <= fwd_s7;

			r1_s9   <= sat(-rnd(t1_s8));
			up_s9   <= up_s8;
			r0_s9   <= r0_s8;
			r2_s9   <= r2_s8;
			side_s9 <= side_s8;
			fwd_s9  <= fwd_s8;
		end
	end

	// Serializer: load a finished matrix, then step through its columns,
	// one per accepted beat; reload on the beat that sends column 3.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			col_q  <= COL_0;
		end else if (load) begin
			busy_q <= 1'b1;
			col_q  <= COL_0;
		end else if (busy_q && mat.ready) begin
			if (col_q == COL_3) begin
				busy_q <= 1'b0;
			end else begin
				col_q <= col_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			up_q   <= up_s9;
			r0_q   <= r0_s9;
			r1_q   <= r1_s9;
			r2_q   <= r2_s9;
			side_q <= side_s9;
			fwd_q  <= fwd_s9;
		end
	end

	assign mat.valid             = busy_q;
	assign mat.data.column_index = col_q;
	assign mat.data.last_column  = (col_q == COL_3);

	always_comb begin
		case (col_q)
			COL_0: begin
				mat.data.elem_row0 = DATA_W'(side_q[0]);
				mat.data.elem_row1 = up_q[0];
				mat.data.elem_row2 = -DATA_W'(fwd_q[0]);
				mat.data.elem_row3 = '0;
			end
			COL_1: begin
				mat.data.elem_row0 = DATA_W'(side_q[1]);
				mat.data.elem_row1 = up_q[1];
				mat.data.elem_row2 = -DATA_W'(fwd_q[1]);
				mat.data.elem_row3 = '0;
			end
			COL_2: begin
				mat.data.elem_row0 = DATA_W'(side_q[2]);
				mat.data.elem_row1 = up_q[2];
				mat.data.elem_row2 = -DATA_W'(fwd_q[2]);
				mat.data.elem_row3 = '0;
			end
			default: begin
				mat.data.elem_row0 = r0_q;
				mat.data.elem_row1 = r1_q;
				mat.data.elem_row2 = r2_q;
				mat.data.elem_row3 = ONE_Q;
			end
		endcase
	end

endmodule

FILE: verif/look_at_view_matrix_test.sv
// Self-checking testbench for the look-at view matrix block.
module look_at_view_matrix_test import lav_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int    F       = FRAC_BITS_DEF;
	localparam word_t ONE     = 32'sh0001_0000;
	localparam word_t W_MAX   = 32'sh7fff_ffff;
	localparam word_t W_MIN   = 32'sh8000_0000;
	// Idle margin at the end of the run; allow plenty for stalls.
	localparam int    TAIL    = 300;
	localparam int    STUCK   = 6000;
	localparam int    N_PHASE = 33;

	typedef longint vec3_t[3];

	// How the expected matrix of a directed row is found.
	typedef enum logic [1:0] {MX_PREDICT, MX_IDENTITY, MX_DEGENERATE} mx_kind_e;

	typedef struct packed {
		lav_in_t  pose;
		mx_kind_e kind;
	} stim_row_t;

	logic clk;
	logic arst_n;

	lav_in_if  cam_ch ();
	lav_out_if mat_ch ();

	look_at_view_matrix dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cam    (cam_ch),
		.mat    (mat_ch)
	);

	lav_out_t column_q[$];
	int       err_cnt;
	int       pose_cnt;
	int       column_cnt;
	int       send_idle_pct;
	int       recv_stall_pct;
	int       quiet_cycles = 0;

	// Directed poses: extremes, the zero forward case, the zero and parallel
	// up hints, and saturating translation terms.
	stim_row_t dir_tab[] = '{
		'{'{0, 0, 0, 0, 0, -ONE, 0, ONE, 0}, MX_IDENTITY},
		'{'{0, 0, 0, 0, 0, 0, 0, ONE, 0}, MX_DEGENERATE},
		'{'{W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MIN, W_MAX, W_MIN}, MX_DEGENERATE},
		'{'{W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MAX, W_MAX, W_MAX}, MX_DEGENERATE},
		'{'{ONE, 2 * ONE, -ONE, 5 * ONE, 0, ONE, 0, 0, 0}, MX_PREDICT},
		'{'{0, ONE, 0, ONE, ONE, 0, 5 * ONE, 0, 0}, MX_PREDICT},
		'{'{0, 0, 0, 3 * ONE, 3 * ONE, 3 * ONE, -ONE, -ONE, -ONE}, MX_PREDICT},
		'{'{W_MIN, W_MIN, W_MIN, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX}, MX_PREDICT},
		'{'{W_MAX, W_MAX, W_MAX, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN}, MX_PREDICT},
		'{'{W_MAX, W_MIN, W_MAX, W_MIN, W_MAX, W_MIN, 1, -1, 1}, MX_PREDICT},
		'{'{W_MAX, W_MAX, W_MAX, 0, 0, 0, 0, ONE, 0}, MX_PREDICT},
		'{'{W_MIN, W_MAX, W_MIN, 0, 0, 0, ONE, 0, 0}, MX_PREDICT},
		'{'{ONE, ONE, ONE, ONE + 1, ONE, ONE, 0, ONE, 0}, MX_PREDICT},
		'{'{-ONE, 7, -3, 0, 0, -1, W_MAX, W_MIN, 0}, MX_PREDICT},
		'{'{0, 0, 0, 32'sh5555_5555, 32'shaaaa_aaaa, 1, 32'shffff_ffff, 0, W_MIN}, MX_PREDICT},
		'{'{32'sh1234_5678, -ONE, 0, 0, 0, 0, 0, 0, ONE}, MX_PREDICT}
	};

	// ---------------------------------------------------------------- predictor

	function automatic longint unsigned mag(longint v);
		return (v < 0) ? longint'(-v) : v;
	endfunction

	function automatic longint with_sign(longint unsigned m, bit neg);
		return neg ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint unsigned int_root(longint unsigned n);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b   = 64'h4000_0000_0000_0000;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n  -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	// Scale to unit length in Q.F; a zero vector stays zero.
	function automatic void unit_vec(input vec3_t v, output vec3_t u);
		longint unsigned m[3];
		longint unsigned mx;
		longint unsigned sum;
		longint unsigned len;
		mx  = 0;
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			m[i] = mag(v[i]);
			if (m[i] > mx) mx = m[i];
		end
		if (mx == 0) begin
			u = '{0, 0, 0};
			return;
		end
		while (mx >= (64'd1 << 30)) begin
			mx >>= 1;
			for (int i = 0; i < 3; i++) m[i] >>= 1;
		end
		while (mx < (64'd1 << 29)) begin
			mx <<= 1;
			for (int i = 0; i < 3; i++) m[i] <<= 1;
		end
		for (int i = 0; i < 3; i++) sum += m[i] * m[i];
		len = int_root(sum);
		for (int i = 0; i < 3; i++)
			u[i] = with_sign(((m[i] << F) + (len >> 1)) / len, v[i] < 0);
	endfunction

	function automatic void cross_prod(input vec3_t a, input vec3_t b, output vec3_t d);
		d[0] = a[1] * b[2] - a[2] * b[1];
		d[1] = a[2] * b[0] - a[0] * b[2];
		d[2] = a[0] * b[1] - a[1] * b[0];
	endfunction

	// Drop F fraction bits, rounding half away from zero.
	function automatic longint drop_frac(longint v);
		return with_sign((mag(v) + (64'd1 << (F - 1))) >> F, v < 0);
	endfunction

	function automatic word_t clamp32(longint v);
		if (v > longint'(W_MAX)) return W_MAX;
		if (v < longint'(W_MIN)) return W_MIN;
		return word_t'(v);
	endfunction

	function automatic lav_out_t make_col(logic [1:0] idx, word_t r0, word_t r1, word_t r2,
		word_t r3);
		lav_out_t c;
		c.column_index = idx;
		c.elem_row0    = r0;
		c.elem_row1    = r1;
		c.elem_row2    = r2;
		c.elem_row3    = r3;
		c.last_column  = (idx == COL_3);
		return c;
	endfunction

	// Work out the four columns of the view matrix for one pose.
	task automatic predict_view(input lav_in_t p);
		vec3_t eye, dif, hint, fwd, tmp, side, up;
		longint t_side, t_up, t_fwd;
		eye  = '{p.eye_x, p.eye_y, p.eye_z};
		hint = '{p.up_hint_x, p.up_hint_y, p.up_hint_z};
		dif  = '{longint'(p.target_x) - eye[0], longint'(p.target_y) - eye[1],
			longint'(p.target_z) - eye[2]};
		unit_vec(dif, fwd);
		cross_prod(fwd, hint, tmp);
		unit_vec(tmp, side);
		cross_prod(side, fwd, tmp);
		for (int i = 0; i < 3; i++) up[i] = drop_frac(tmp[i]);
		t_side = side[0] * eye[0] + side[1] * eye[1] + side[2] * eye[2];
		t_up   = up[0] * eye[0] + up[1] * eye[1] + up[2] * eye[2];
		t_fwd  = fwd[0] * eye[0] + fwd[1] * eye[1] + fwd[2] * eye[2];
		for (int i = 0; i < 3; i++)
			column_q.push_back(make_col(i[1:0], clamp32(side[i]), clamp32(up[i]),
				clamp32(-fwd[i]), 0));
		column_q.push_back(make_col(COL_3, clamp32(-drop_frac(t_side)),
			clamp32(-drop_frac(t_up)), clamp32(drop_frac(t_fwd)), ONE));
	endtask

	// Queue the columns of an accepted pose, typed in or predicted.
	task automatic expect_pose(input lav_in_t p, input mx_kind_e kind);
		case (kind)
			MX_IDENTITY: begin
				column_q.push_back(make_col(COL_0, ONE, 0, 0, 0));
				column_q.push_back(make_col(COL_1, 0, ONE, 0, 0));
				column_q.push_back(make_col(COL_2, 0, 0, ONE, 0));
				column_q.push_back(make_col(COL_3, 0, 0, 0, ONE));
			end
			MX_DEGENERATE: begin
				column_q.push_back(make_col(COL_0, 0, 0, 0, 0));
				column_q.push_back(make_col(COL_1, 0, 0, 0, 0));
				column_q.push_back(make_col(COL_2, 0, 0, 0, 0));
				column_q.push_back(make_col(COL_3, 0, 0, 0, ONE));
			end
			default: predict_view(p);
		endcase
	endtask

	// ---------------------------------------------------------------- stimulus

	function automatic word_t rand_word();
		case ($urandom_range(3))
			0: return word_t'($urandom);
			1: return word_t'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
			2: case ($urandom_range(4))
				0: return W_MAX;
				1: return W_MIN;
				2: return 0;
				3: return ONE;
				default: return -ONE;
			endcase
			default: return word_t'(int'($urandom_range(0, 1 << 27)) - (1 << 26));
		endcase
	endfunction

	// Mostly general poses; some hit eye on target, a zero up hint or an up
	// hint along the line of sight.
	function automatic lav_in_t rand_pose();
		lav_in_t p;
		int      k;
		p = {rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
			rand_word(), rand_word(), rand_word(), rand_word()};
		case ($urandom_range(9))
			0: begin
				p.target_x = p.eye_x;
				p.target_y = p.eye_y;
				p.target_z = p.eye_z;
			end
			1: {p.up_hint_x, p.up_hint_y, p.up_hint_z} = '0;
			2: begin
				k = int'($urandom_range(1, 7)) - 4;
				p.eye_x    = word_t'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
				p.eye_y    = word_t'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
				p.eye_z    = word_t'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
				p.up_hint_x = word_t'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
				p.up_hint_y = word_t'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
				p.up_hint_z = word_t'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
				p.target_x = p.eye_x + k * p.up_hint_x;
				p.target_y = p.eye_y + k * p.up_hint_y;
				p.target_z = p.eye_z + k * p.up_hint_z;
			end
			default: ;
		endcase
		return p;
	endfunction

	// Offer one pose and hold it until the block takes it; idle first at the
	// rate of the current phase.
	task automatic send_pose(input lav_in_t p, input mx_kind_e kind);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			cam_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		cam_ch.valid <= 1'b1;
		cam_ch.data  <= p;
		do @(posedge clk); while (!cam_ch.ready);
		expect_pose(p, kind);
		pose_cnt++;
	endtask

	task automatic wait_drained();
		while (column_q.size() != 0) @(posedge clk);
	endtask

	// ---------------------------------------------------------------- checking

	task automatic report_mismatch(input string what, input longint got, input longint want);
		err_cnt++;
		$display("%0t mismatch col %0d %s: got %0d expected %0d", $realtime, column_cnt,
			what, got, want);
	endtask

	always @(posedge clk) begin
		lav_out_t got, want;
		if (mat_ch.valid && mat_ch.ready) begin
			got = mat_ch.data;
			if (column_q.size() == 0) begin
				report_mismatch("unexpected beat, column_index", got.column_index, -1);
			end else begin
				want = column_q.pop_front();
				if (got.column_index !== want.column_index)
					report_mismatch("column_index", got.column_index, want.column_index);
				if (got.elem_row0 !== want.elem_row0)
					report_mismatch("elem_row0", got.elem_row0, want.elem_row0);
				if (got.elem_row1 !== want.elem_row1)
					report_mismatch("elem_row1", got.elem_row1, want.elem_row1);
				if (got.elem_row2 !== want.elem_row2)
					report_mismatch("elem_row2", got.elem_row2, want.elem_row2);
				if (got.elem_row3 !== want.elem_row3)
					report_mismatch("elem_row3", got.elem_row3, want.elem_row3);
				if (got.last_column !== want.last_column)
					report_mismatch("last_column", got.last_column, want.last_column);
			end
			column_cnt++;
		end
	end

	// ---------------------------------------------------------------- clock, stalls, watchdog

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Stall the column side at the rate of the current phase.
	always @(posedge clk)
		mat_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

	// End the run if no beat moves on either side for too long.
	always @(posedge clk) begin
		if ((cam_ch.valid && cam_ch.ready) || (mat_ch.valid && mat_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STUCK) begin
			$display("watchdog: no beat for %0d cycles, %0d columns pending", STUCK,
				column_q.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	// ---------------------------------------------------------------- main sequence

	initial begin
		err_cnt        = 0;
		pose_cnt       = 0;
		column_cnt     = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		arst_n         = 1'b0;
		cam_ch.valid  <= 1'b0;
		cam_ch.data   <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table, light receiver stalls.
		recv_stall_pct = 20;
		foreach (dir_tab[i]) send_pose(dir_tab[i].pose, dir_tab[i].kind);

		// Hold off until the directed matrices have all come back.
		cam_ch.valid <= 1'b0;
		wait_drained();

		// Random poses over four idling phases: none, sender, receiver, both.
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct  = (ph == 1) ? 55 : (ph == 3) ? 6 : 0;
			recv_stall_pct = (ph == 2) ? 55 : (ph == 3) ? 6 : 0;
			repeat (N_PHASE) send_pose(rand_pose(), MX_PREDICT);
		end
		cam_ch.valid <= 1'b0;
		recv_stall_pct = 0;

		wait_drained();
		repeat (TAIL) @(posedge clk);

		$display("covered %0d poses (directed extremes, eye on target, degenerate up) and",
			pose_cnt);
		$display("checked %0d columns across free-running, sender-idle and stalled phases",
			column_cnt);
		if (err_cnt == 0 && column_q.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
